// ===== rtl/cubic_bezier_point_generator_core_defines.svh =====
// ----------------------------------------------------------------------------
// cubic bezier point generator assertion macros
// shared property wrappers for the port-level checker
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_POINT_GENERATOR_CORE_DEFINES_SVH
`define CUBIC_BEZIER_POINT_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CBPG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, disabled during reset
`define CBPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

// condition that must hold in the cycle after reset is asserted
`define CBPG_ASSERT_RST(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== rtl/cbpg_pkg.sv =====
// ----------------------------------------------------------------------------
// cbpg_pkg
// widths, command and status types shared by the bezier point generator
// ----------------------------------------------------------------------------
package cbpg_pkg;

    localparam int COORD_W    = 24;
    localparam int NUM_COORDS = 8;
    localparam int CNT_W      = 7;
    localparam int MAX_POINTS = 64;

    localparam int IN_DATA_W  = ((NUM_COORDS * COORD_W + CNT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * COORD_W + 7) / 8) * 8;

    localparam int IDX_W  = $clog2(MAX_POINTS + 1);
    localparam int T_FRAC = 16;
    localparam int T_W    = T_FRAC + 1;
    localparam int DVD_W  = IDX_W + T_FRAC;
    localparam int DCNT_W = $clog2(DVD_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_WGT,
        ST_MAC,
        ST_OUT
    } t_state;

    // weight unit operations, in issue order
    typedef enum logic [2:0] {
        WOP_UU = 3'd0,
        WOP_TT = 3'd1,
        WOP_W0 = 3'd2,
        WOP_W1 = 3'd3,
        WOP_W2 = 3'd4,
        WOP_W3 = 3'd5
    } t_wop;

    typedef struct packed {
        logic       load;
        logic       t_zero;
        logic       t_div;
        logic       div_start;
        logic       wgt_en;
        t_wop       wop;
        logic       mac_en;
        logic       mac_clr;
        logic [1:0] mac_k;
        logic       out_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic run_empty;
        logic idx_zero;
        logic idx_last;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/cbpg_div.sv =====
// ----------------------------------------------------------------------------
// cbpg_div
// restoring divider, one quotient bit per cycle, forms the curve parameter t
// ----------------------------------------------------------------------------
module cbpg_div import cbpg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [IDX_W-1:0] i_divisor,
    output logic             o_done,
    output logic [T_W-1:0]   o_quotient
);

    logic [DVD_W-1:0]  r_quo;
    logic [IDX_W-1:0]  r_rem;
    logic [IDX_W-1:0]  r_dvs;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [IDX_W:0] rem_sh;
    logic           ge;
    logic [IDX_W:0] rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DVD_W-1]};
        ge      = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
            r_done <= !i_start && r_busy && (r_cnt == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], ge};
            r_rem <= ge ? rem_sub[IDX_W-1:0] : rem_sh[IDX_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[T_W-1:0];

endmodule

// ===== rtl/cbpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbpg_ctrl
// sequencer: per point runs divide (skipped for the first point), weight, multiply-accumulate and output
// ----------------------------------------------------------------------------
module cbpg_ctrl import cbpg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_valid,
    input  t_dp_stat i_stat,
    output logic     o_s_ready,
    output t_dp_cmd  o_cmd
);

    localparam int STEP_W   = 3;
    localparam int WGT_LAST = 5;
    localparam int MAC_LAST = 3;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        o_s_ready = 1'b0;
        o_cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_START;
                end
            end
            ST_START: begin
                if (i_stat.run_empty) begin
                    n_state = ST_IDLE;
                end else if (i_stat.idx_zero) begin
                    // first point sits at t = 0, no divide needed
                    o_cmd.t_zero = 1'b1;
                    n_state      = ST_WGT;
                    n_step       = '0;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.t_div = 1'b1;
                    n_state     = ST_WGT;
                    n_step      = '0;
                end
            end
            ST_WGT: begin
                o_cmd.wgt_en = 1'b1;
                o_cmd.wop    = t_wop'(r_step);
                if (r_step == STEP_W'(WGT_LAST)) begin
                    n_state = ST_MAC;
                    n_step  = '0;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_MAC: begin
                o_cmd.mac_en  = 1'b1;
                o_cmd.mac_clr = (r_step == '0);
                o_cmd.mac_k   = r_step[1:0];
                if (r_step == STEP_W'(MAC_LAST)) begin
                    n_state = ST_OUT;
                    n_step  = '0;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_wr = 1'b1;
                    n_state      = i_stat.idx_last ? ST_IDLE : ST_START;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/cbpg_datapath.sv =====
// ----------------------------------------------------------------------------
// cbpg_datapath
// curve registers, bernstein weight unit, x/y accumulators and output register
// ----------------------------------------------------------------------------
module cbpg_datapath import cbpg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [IN_DATA_W-1:0]  i_curve,
    input  logic                  i_m_ready,
    output t_dp_stat              o_stat,
    output logic                  o_m_valid,
    output logic [OUT_DATA_W-1:0] o_m_data,
    output logic                  o_m_last
);

    localparam int SQ_W     = 2 * T_FRAC + 1;
    localparam int WGT_W    = 2 * T_FRAC + 1;
    localparam int WGT_FRAC = 2 * T_FRAC;
    localparam int T3_W     = T_FRAC + 2;
    localparam int PROD_W   = SQ_W + T3_W;
    localparam int ACC_W    = WGT_W + 1 + COORD_W;
    localparam int RND_W    = ACC_W - WGT_FRAC;
    localparam int T_ONE    = 1 << T_FRAC;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (WGT_FRAC - 1);
    localparam logic signed [RND_W-1:0] SAT_HI =
        {{(RND_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
    localparam logic signed [RND_W-1:0] SAT_LO =
        {{(RND_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};

    function automatic logic signed [COORD_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] a
    );
        logic signed [ACC_W-1:0] b;
        logic signed [RND_W-1:0] r;
        b = a + ROUND_BIAS;
        r = b[ACC_W-1:WGT_FRAC];
        if (r > SAT_HI) begin
            return SAT_HI[COORD_W-1:0];
        end else if (r < SAT_LO) begin
            return SAT_LO[COORD_W-1:0];
        end
        return r[COORD_W-1:0];
    endfunction

    logic signed [COORD_W-1:0] r_pts [NUM_COORDS];
    logic [IDX_W-1:0]          r_len;
    logic [IDX_W-1:0]          r_idx;
    logic [T_W-1:0]            r_t;
    logic [T_W-1:0]            r_u;
    logic [T3_W-1:0]           r_t3;
    logic [T3_W-1:0]           r_u3;
    logic [SQ_W-1:0]           r_uu;
    logic [SQ_W-1:0]           r_tt;
    logic [WGT_W-1:0]          r_w [4];
    logic signed [ACC_W-1:0]   r_acc_x;
    logic signed [ACC_W-1:0]   r_acc_y;
    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_out_x;
    logic signed [COORD_W-1:0] r_out_y;
    logic                      r_out_last;

    logic [CNT_W-1:0] in_cnt;
    logic [IDX_W-1:0] n_len;
    logic             div_done;
    logic [T_W-1:0]   div_quo;
    logic [T_W-1:0]   t_new;
    logic [T3_W-1:0]  t3_new;
    logic [SQ_W-1:0]  mul_a;
    logic [T3_W-1:0]  mul_b;
    logic [PROD_W-1:0] wprod;
    logic signed [ACC_W-1:0] prod_x;
    logic signed [ACC_W-1:0] prod_y;
    logic             idx_last;
    logic             out_free;

    cbpg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({r_idx, T_FRAC'(0)}),
        .i_divisor  (r_len - IDX_W'(1)),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        in_cnt = i_curve[NUM_COORDS * COORD_W +: CNT_W];
        n_len  = (32'(in_cnt) > MAX_POINTS) ? IDX_W'(MAX_POINTS) : IDX_W'(in_cnt);
        t_new  = i_cmd.t_zero ? '0 : div_quo;
        t3_new = T3_W'(t_new) + (T3_W'(t_new) << 1);
    end

    // shared weight multiplier, operands picked per step
    always_comb begin
        unique case (i_cmd.wop)
            WOP_UU: begin
                mul_a = SQ_W'(r_u);
                mul_b = T3_W'(r_u);
            end
            WOP_TT: begin
                mul_a = SQ_W'(r_t);
                mul_b = T3_W'(r_t);
            end
            WOP_W0: begin
                mul_a = r_uu;
                mul_b = T3_W'(r_u);
            end
            WOP_W1: begin
                mul_a = r_uu;
                mul_b = r_t3;
            end
            WOP_W2: begin
                mul_a = r_tt;
                mul_b = r_u3;
            end
            WOP_W3: begin
                mul_a = r_tt;
                mul_b = T3_W'(r_t);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        wprod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_comb begin
        prod_x = $signed({1'b0, r_w[i_cmd.mac_k]}) * r_pts[{i_cmd.mac_k, 1'b0}];
        prod_y = $signed({1'b0, r_w[i_cmd.mac_k]}) * r_pts[{i_cmd.mac_k, 1'b1}];
    end

    assign idx_last = ({1'b0, r_idx} + (IDX_W + 1)'(1)) == {1'b0, r_len};
    assign out_free = !r_out_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_len <= n_len;
                r_idx <= '0;
            end else if (i_cmd.out_wr) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.out_wr) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < NUM_COORDS; k++) begin
                r_pts[k] <= i_curve[k * COORD_W +: COORD_W];
            end
        end
        if (i_cmd.t_zero || i_cmd.t_div) begin
            r_t  <= t_new;
            r_u  <= T_W'(T_ONE) - t_new;
            r_t3 <= t3_new;
            r_u3 <= T3_W'(3 * T_ONE) - t3_new;
        end
        if (i_cmd.wgt_en) begin
            unique case (i_cmd.wop)
                WOP_UU:  r_uu   <= wprod[SQ_W-1:0];
                WOP_TT:  r_tt   <= wprod[SQ_W-1:0];
                WOP_W0:  r_w[0] <= wprod[T_FRAC +: WGT_W];
                WOP_W1:  r_w[1] <= wprod[T_FRAC +: WGT_W];
                WOP_W2:  r_w[2] <= wprod[T_FRAC +: WGT_W];
                WOP_W3:  r_w[3] <= wprod[T_FRAC +: WGT_W];
                default: r_uu   <= r_uu;
            endcase
        end
        if (i_cmd.mac_en) begin
            r_acc_x <= (i_cmd.mac_clr ? '0 : r_acc_x) + prod_x;
            r_acc_y <= (i_cmd.mac_clr ? '0 : r_acc_y) + prod_y;
        end
        if (i_cmd.out_wr) begin
            r_out_x    <= round_sat(r_acc_x);
            r_out_y    <= round_sat(r_acc_y);
            r_out_last <= idx_last;
        end
    end

    always_comb begin
        o_stat.run_empty = (r_len == '0);
        o_stat.idx_zero  = (r_idx == '0);
        o_stat.idx_last  = idx_last;
        o_stat.div_done  = div_done;
        o_stat.out_free  = out_free;
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = OUT_DATA_W'({r_out_y, r_out_x});
    assign o_m_last  = r_out_last;

endmodule

// ===== rtl/cubic_bezier_point_generator_core.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_point_generator_core
// emits evenly spaced points of one cubic bezier curve per input transaction
// ----------------------------------------------------------------------------
// usage:
//   slave channel takes one curve per transaction: four points and a count.
//   master channel returns that many (x, y) points, tlast on the final one;
//   a count of zero returns nothing, counts above 64 are clamped to 64.
//   s_axis_tready is high only while no curve is in progress, so curves are
//   handled one at a time.
//   each point runs a start step, the one-bit-per-cycle divider forming t
//   (skipped for the first point of a curve), six steps of the shared weight
//   multiplier, four x/y multiply-accumulate steps and the output write.
//   a single output register decouples the sides: the next point is computed
//   while the previous one waits, and when m_axis_tready stays low the
//   sequencer holds at the output write, the waiting point held stable.
//   synchronous active-low reset returns to idle and drops m_axis_tvalid.
// ----------------------------------------------------------------------------
module cubic_bezier_point_generator_core import cbpg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
    // point_count, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // point_x, point_y
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    cbpg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_stat    (dp_stat),
        .o_s_ready (s_axis_tready),
        .o_cmd     (dp_cmd)
    );

    cbpg_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (dp_cmd),
        .i_curve   (s_axis_tdata),
        .i_m_ready (m_axis_tready),
        .o_stat    (dp_stat),
        .o_m_valid (m_axis_tvalid),
        .o_m_data  (m_axis_tdata),
        .o_m_last  (m_axis_tlast)
    );

endmodule

// ===== rtl/cbpg_checker.sv =====
// ----------------------------------------------------------------------------
// cbpg_checker
// port-level assertions for the bezier point generator, bound to the top
// ----------------------------------------------------------------------------
`include "cubic_bezier_point_generator_core_defines.svh"

module cbpg_checker import cbpg_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    // reset empties the output register
    `CBPG_ASSERT_RST(a_rst_out_empty, i_clk, i_rst_n, !m_axis_tvalid)

    // stalled point holds
    `CBPG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // a taken curve keeps the block busy in the cycle after it is taken
    `CBPG_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // no new curve while a run still owes its last point
    `CBPG_ASSERT_IMPL(a_no_take_mid_run, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

endmodule

bind cubic_bezier_point_generator_core cbpg_checker u_cbpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
